// File: sv/ksm_pkg.sv
`default_nettype none
package ksm_pkg;

  localparam int unsigned PIN_COUNT = 12;
  localparam int unsigned STATUS_W  = 8;
  localparam int unsigned NOTE_W    = 7;
  localparam int unsigned VEL_W     = 7;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned IN_DATA_W  = 16;  // 12 key pins + exit pin, padded to bytes
  localparam int unsigned OUT_DATA_W = 24;  // status + note + velocity, padded to bytes

  localparam logic [STATUS_W-1:0] ST_NOTE_ON  = 8'h90;
  localparam logic [STATUS_W-1:0] ST_NOTE_OFF = 8'h80;
  localparam logic [STATUS_W-1:0] ST_EXIT     = 8'hFF;

  localparam logic [CFG_W-1:0] RESET_BASE_NOTE = 7'd60;
  localparam logic [CFG_W-1:0] RESET_VELOCITY  = 7'd127;

  // register indexes of the configuration port
  localparam logic CFG_BASE_NOTE = 1'b0;
  localparam logic CFG_PRESS_VEL = 1'b1;

  typedef struct packed {
    logic load;  // take a scan sample and update the pressed mask
    logic emit;  // send the next pending message into the output register
  } ksm_cmd_t;

  typedef struct packed {
    logic busy;      // messages of the current scan still pending
    logic out_free;  // output register can take a message this cycle
  } ksm_sts_t;

endpackage
`default_nettype wire

// File: sv/ksm_ctrl.sv
`default_nettype none
module ksm_ctrl
  import ksm_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire ksm_sts_t sts_i,
  output ksm_cmd_t      cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        if (!sts_i.busy) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // no scan work may be left over when a new sample can be taken
  a_idle_no_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !sts_i.busy)
    else $error("ksm_ctrl: idle with pending messages");

  a_emit_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |-> (state_q == ST_RUN))
    else $error("ksm_ctrl: emit outside run state");

endmodule
`default_nettype wire

// File: sv/ksm_dp.sv
`default_nettype none
module ksm_dp
  import ksm_pkg::*;
#(
  parameter int unsigned NUM_KEYS = 12
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_index_i,
  input  wire logic [CFG_W-1:0]      cfg_data_i,
  input  wire logic [PIN_COUNT-1:0]  key_pins_i,
  input  wire logic                  exit_pin_i,
  input  wire ksm_cmd_t              cmd_i,
  output ksm_sts_t                   sts_o,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [STATUS_W-1:0]        status_byte_o,
  output logic [NOTE_W-1:0]          note_number_o,
  output logic [VEL_W-1:0]           velocity_o,
  output logic                       last_of_scan_o
);

  localparam int unsigned ScanKeys = (NUM_KEYS < PIN_COUNT) ? NUM_KEYS : PIN_COUNT;
  localparam int unsigned KeyW     = (ScanKeys > 1) ? $clog2(ScanKeys) : 1;

  logic [CFG_W-1:0]    base_q, vel_q;
  logic [ScanKeys-1:0] mask_q, pend_q, pend_d;
  logic                exit_q, exit_d;
  logic [ScanKeys-1:0] now_keys, pend_rest;
  logic [KeyW-1:0]     sel;
  logic                out_valid_q;
  logic [STATUS_W-1:0] status_q, status_d;
  logic [NOTE_W-1:0]   note_q, note_d;
  logic [VEL_W-1:0]    vel_out_q, vel_out_d;
  logic                last_q, last_d;

  assign now_keys  = ~key_pins_i[ScanKeys-1:0];
  assign pend_rest = pend_q & (pend_q - ScanKeys'(1));  // drop lowest pending key

  // lowest pending key
  always_comb begin
    sel = '0;
    for (int i = ScanKeys - 1; i >= 0; i--) begin
      if (pend_q[i]) begin
        sel = KeyW'(i);
      end
    end
  end

  always_comb begin
    pend_d    = pend_q;
    exit_d    = exit_q;
    status_d  = ST_EXIT;
    note_d    = '0;
    vel_out_d = '0;
    last_d    = 1'b1;
    if (cmd_i.load) begin
      pend_d = now_keys ^ mask_q;
      exit_d = !exit_pin_i;
    end else if (pend_q != '0) begin
      note_d = base_q + NOTE_W'(sel);
      if (mask_q[sel]) begin
        status_d  = ST_NOTE_ON;
        vel_out_d = vel_q;
      end else begin
        status_d = ST_NOTE_OFF;
      end
      last_d = (pend_rest == '0) && !exit_q;
      if (cmd_i.emit) begin
        pend_d = pend_rest;
      end
    end else if (cmd_i.emit) begin
      exit_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q      <= RESET_BASE_NOTE;
      vel_q       <= RESET_VELOCITY;
      mask_q      <= '0;
      pend_q      <= '0;
      exit_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_BASE_NOTE: base_q <= cfg_data_i;
          CFG_PRESS_VEL: vel_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        mask_q <= now_keys;
      end
      pend_q <= pend_d;
      exit_q <= exit_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_q  <= status_d;
      note_q    <= note_d;
      vel_out_q <= vel_out_d;
      last_q    <= last_d;
    end
  end

  assign sts_o.busy     = (pend_q != '0) || exit_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o    = out_valid_q;
  assign status_byte_o  = status_q;
  assign note_number_o  = note_q;
  assign velocity_o     = vel_out_q;
  assign last_of_scan_o = last_q;

  a_emit_has_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (sts_o.out_free && sts_o.busy))
    else $error("ksm_dp: emit without room or without work");

  a_last_ends_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && last_d) |=> !sts_o.busy)
    else $error("ksm_dp: work left after last message");

  a_no_load_while_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> !sts_o.busy)
    else $error("ksm_dp: new scan loaded over pending messages");

endmodule
`default_nettype wire

// File: sv/key_scan_to_midi_note_events_core.sv
// The first message of a scan goes into the output register once the sample has been
// registered as pending keys. A scan causes N messages (at most 13), sent by the
// message sequencer at one message per cycle; a stalled output holds the sequencer.
// A scan with no changes and no exit request sends no message. A new sample is taken only when idle.
// Reset (rst_ni low, asynchronous): pressed mask cleared, base note 60, velocity 127.
`default_nettype none
module key_scan_to_midi_note_events_core
  import ksm_pkg::*;
#(
  parameter int unsigned NUM_KEYS = 12
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic                  cfg_index_i,
  input  wire logic [CFG_W-1:0]      cfg_data_i,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // key_pins[11:0], exit_pin[12]
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // status_byte[7:0], note_number[14:8],
                                                     // velocity[21:15]
  output logic                       m_axis_tlast    // last_of_scan
);

  ksm_cmd_t            cmd;
  ksm_sts_t            sts;
  logic [STATUS_W-1:0] status_byte;
  logic [NOTE_W-1:0]   note_number;
  logic [VEL_W-1:0]    velocity;

  ksm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ksm_dp #(
    .NUM_KEYS (NUM_KEYS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .key_pins_i     (s_axis_tdata[PIN_COUNT-1:0]),
    .exit_pin_i     (s_axis_tdata[PIN_COUNT]),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .status_byte_o  (status_byte),
    .note_number_o  (note_number),
    .velocity_o     (velocity),
    .last_of_scan_o (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, velocity, note_number, status_byte};

endmodule
`default_nettype wire
